@@ hw/rtl/arso_pkg.sv @@
// arso_pkg: shared widths, register and axis codes and the multiplier command type
// for the attitude rate state observer
// depends on nothing
package arso_pkg;

   localparam int AXES_DEFAULT = 3;
   localparam int WORD_W       = 32;
   localparam int INERTIA_W    = 31;
   localparam int AXIS_W       = 2;
   localparam int CSR_IDX_W    = 2;

   // accumulator of the shared multiplier, wide enough for a 50 x 32 bit product
   localparam int ACC_W  = 82;
   // divider: dividend is a 47-bit value shifted up by 16
   localparam int DIVD_W = 63;
   localparam int CNT_W  = 6;

   localparam logic [WORD_W-1:0] STEP_RESET = 32'd4294967;

   localparam logic [CSR_IDX_W-1:0] REG_ROLL_BW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_BW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_BW   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP     = 2'd3;

   localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_EXTRA = 2'd3;

   typedef struct packed {
      logic issue;   // launch a product this cycle
      logic upper;   // product lands 32 bits up
      logic clear;   // start a fresh sum instead of adding
   } mul_cmd_type;

endpackage

@@ hw/rtl/arso_mul.sv @@
// arso_mul: shared 32 x 32 multiplier with a registered product and a wide accumulator
// depends on arso_pkg
module arso_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  arso_pkg::mul_cmd_type         cmd,
   input  logic [arso_pkg::WORD_W-1:0]   op_a,
   input  logic [arso_pkg::WORD_W-1:0]   op_b,
   output logic [arso_pkg::ACC_W-1:0]    acc
);

   logic [2*arso_pkg::WORD_W-1:0] prod_ff;
   logic                          vld_ff;
   logic                          upper_ff;
   logic                          clear_ff;
   logic [arso_pkg::ACC_W-1:0]    acc_ff;
   logic [arso_pkg::ACC_W-1:0]    acc_in;
   logic [arso_pkg::ACC_W-1:0]    addend;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.issue;
      end
      prod_ff  <= op_a * op_b;
      upper_ff <= cmd.upper;
      clear_ff <= cmd.clear;
   end

   // accumulate stage
   always_comb begin
      if (upper_ff) begin
         addend = {prod_ff[arso_pkg::ACC_W-arso_pkg::WORD_W-1:0], {arso_pkg::WORD_W{1'b0}}};
      end else begin
         addend = arso_pkg::ACC_W'(prod_ff);
      end
      acc_in = (clear_ff ? '0 : acc_ff) + addend;
   end

   always_ff @(posedge clock) begin
      if (vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ hw/rtl/arso_div.sv @@
// arso_div: restoring divider, one quotient bit per cycle
// depends on arso_pkg
module arso_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [arso_pkg::DIVD_W-1:0]      dividend,
   input  logic [arso_pkg::INERTIA_W-1:0]   divisor,
   output logic                             busy,
   output logic [arso_pkg::DIVD_W-1:0]      quotient
);

   logic [arso_pkg::DIVD_W-1:0]    quo_ff;
   logic [arso_pkg::DIVD_W-1:0]    quo_in;
   logic [arso_pkg::INERTIA_W-1:0] rem_ff;
   logic [arso_pkg::INERTIA_W-1:0] rem_in;
   logic [arso_pkg::INERTIA_W-1:0] den_ff;
   logic [arso_pkg::CNT_W-1:0]     cnt_ff;
   logic                           busy_ff;
   logic [arso_pkg::INERTIA_W:0]   trial;
   logic [arso_pkg::INERTIA_W+1:0] diff;
   logic                           fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[arso_pkg::DIVD_W-1]};
      diff   = {1'b0, trial} - {2'b00, den_ff};
      fits   = ~diff[arso_pkg::INERTIA_W+1];
      rem_in = fits ? diff[arso_pkg::INERTIA_W-1:0] : trial[arso_pkg::INERTIA_W-1:0];
      quo_in = {quo_ff[arso_pkg::DIVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= arso_pkg::CNT_W'(arso_pkg::DIVD_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/attitude_rate_state_observer.sv @@
// attitude_rate_state_observer: top level, sequencer, per-axis state and config registers
// depends on arso_pkg, arso_mul, arso_div
//
// usage
// - req channel: one word per axis update; tuser carries the axis, tdata the measured rate,
//   applied torque, feedforward torque, gyroscopic term and inertia
// - rsp channel: one word per request; tuser echoes the axis, tdata holds the new rate
//   estimate z1 and disturbance estimate z2, both saturated to 32 bits
// - csr port: single-cycle writes of the three axis bandwidths and the step size; write
//   only while no update is in flight
// - pacing: the 63-step serial divider for the z1 update sets the pace, and the five
//   products run on one shared multiplier, the last three alongside it; one request is in
//   work at a time, so a new request is not taken until the last one is finished
// - req_tready is high only while the sequencer is idle; the response sits in an output
//   register, so a new request is taken while it waits, and the sequencer then holds its
//   finished result until the output register frees up
// - reset (synchronous) clears both estimates of every axis, the bandwidths to zero and
//   the step size to about 1 ms; no clearing pass is needed
// - an axis code beyond the state array leaves the state alone and answers zeros
module attitude_rate_state_observer #(
   parameter int AXES = arso_pkg::AXES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // measured_rate, applied_torque, feedforward_torque,
                                     // gyro_torque, inertia (31 bits), one zero pad bit
   input  logic [1:0]   req_tuser,   // axis
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // rate_estimate, disturbance_estimate
   output logic [1:0]   rsp_tuser,   // axis_out
   // config writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int W     = arso_pkg::WORD_W;
   localparam int JW    = arso_pkg::INERTIA_W;
   localparam int AW    = arso_pkg::ACC_W;

   localparam logic [W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [W-1:0] SAT_MIN = 32'h8000_0000;

   // sequencer codes
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_LOAD    = 5'd1;
   localparam logic [4:0] ST_P_ISSUE = 5'd2;
   localparam logic [4:0] ST_P_WAIT  = 5'd3;
   localparam logic [4:0] ST_SUM     = 5'd4;
   localparam logic [4:0] ST_T_LO    = 5'd5;
   localparam logic [4:0] ST_T_HI    = 5'd6;
   localparam logic [4:0] ST_T_WAIT  = 5'd7;
   localparam logic [4:0] ST_DIV     = 5'd8;
   localparam logic [4:0] ST_B2_WAIT = 5'd9;
   localparam logic [4:0] ST_B2      = 5'd10;
   localparam logic [4:0] ST_HB_LO   = 5'd11;
   localparam logic [4:0] ST_HB_HI   = 5'd12;
   localparam logic [4:0] ST_HB_WAIT = 5'd13;
   localparam logic [4:0] ST_HB      = 5'd14;
   localparam logic [4:0] ST_G_LO    = 5'd15;
   localparam logic [4:0] ST_G_HI    = 5'd16;
   localparam logic [4:0] ST_G_WAIT  = 5'd17;
   localparam logic [4:0] ST_G       = 5'd18;
   localparam logic [4:0] ST_FIN     = 5'd19;

   // clamp a 35-bit signed sum to 32 bits
   function automatic logic [31:0] sat35(input logic [34:0] v);
      logic all_same;
      all_same = (v[34:31] == 4'b0000) || (v[34:31] == 4'b1111);
      if (all_same) begin
         return v[31:0];
      end
      return v[34] ? SAT_MIN : SAT_MAX;
   endfunction

   // config registers
   logic [W-1:0] bw_roll_ff;
   logic [W-1:0] bw_pitch_ff;
   logic [W-1:0] bw_yaw_ff;
   logic [W-1:0] step_ff;

   // per-axis estimates
   logic [W-1:0] obs_rate_ff [AXES];
   logic [W-1:0] obs_dist_ff [AXES];

   // sequencer and working registers
   logic [4:0]    state_ff;
   logic [4:0]    state_in;
   logic [1:0]    axis_ff;
   logic [W-1:0]  rate_ff;
   logic [W-1:0]  appl_ff;
   logic [W-1:0]  ffwd_ff;
   logic [W-1:0]  gyro_ff;
   logic [JW-1:0] inertia_ff;
   logic          ax_ok_ff;
   logic [W-1:0]  z1_ff;
   logic [W-1:0]  z2_ff;
   logic [W-1:0]  me_ff;
   logic          e_neg_ff;
   logic [34:0]   c0_ff;
   logic [W-1:0]  w0_ff;
   logic [49:0]   s_mag_ff;
   logic          s_neg_ff;
   logic [47:0]   x_ff;
   logic [W-1:0]  z2n_ff;

   // output register
   logic          rsp_valid_ff;
   logic [1:0]    rsp_axis_ff;
   logic [W-1:0]  rsp_rate_ff;
   logic [W-1:0]  rsp_dist_ff;

   logic [IDX_W-1:0] idx;
   logic             ax_ok;
   logic [W-1:0]     w0_sel;
   logic [W-1:0]     z1_rd;
   logic [W-1:0]     z2_rd;
   logic [32:0]      e33;
   logic [32:0]      e_abs;
   logic [34:0]      c0_in;
   logic [48:0]      p2;
   logic [50:0]      s51;
   logic [50:0]      s_abs;
   logic [46:0]      t47;
   logic             g_big;
   logic [32:0]      g_lo;
   logic             d_big;
   logic [32:0]      d_lo;
   logic [W-1:0]     z1n;
   logic [W-1:0]     z2n_in;
   logic             out_free;
   logic             finish;
   logic             req_take;

   // shared units
   arso_pkg::mul_cmd_type      mul_cmd;
   logic [W-1:0]               mul_a;
   logic [W-1:0]               mul_b;
   logic [AW-1:0]              acc;
   logic                       div_start;
   logic                       div_busy;
   logic [arso_pkg::DIVD_W-1:0] div_dividend;
   logic [arso_pkg::DIVD_W-1:0] div_quo;

   arso_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .acc   (acc)
   );

   arso_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (inertia_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign req_take = req_tvalid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign finish   = (state_ff == ST_FIN) && !div_busy && out_free;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_roll_ff  <= '0;
         bw_pitch_ff <= '0;
         bw_yaw_ff   <= '0;
         step_ff     <= arso_pkg::STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            arso_pkg::REG_ROLL_BW:  bw_roll_ff  <= csr_wdata;
            arso_pkg::REG_PITCH_BW: bw_pitch_ff <= csr_wdata;
            arso_pkg::REG_YAW_BW:   bw_yaw_ff   <= csr_wdata;
            arso_pkg::REG_STEP:     step_ff     <= csr_wdata;
            default:                step_ff     <= step_ff;
         endcase
      end
   end

   // state lookup and the first error terms
   always_comb begin
      idx   = IDX_W'(axis_ff);
      ax_ok = ({30'd0, axis_ff} < 32'(AXES));
      z1_rd = obs_rate_ff[idx];
      z2_rd = obs_dist_ff[idx];
      unique case (axis_ff)
         arso_pkg::AXIS_ROLL:  w0_sel = bw_roll_ff;
         arso_pkg::AXIS_PITCH: w0_sel = bw_pitch_ff;
         arso_pkg::AXIS_YAW:   w0_sel = bw_yaw_ff;
         arso_pkg::AXIS_EXTRA: w0_sel = '0;
         default:              w0_sel = '0;
      endcase
      e33   = {z1_rd[W-1], z1_rd} - {rate_ff[W-1], rate_ff};
      e_abs = e33[32] ? (33'd0 - e33) : e33;
      c0_in = {{3{z2_rd[W-1]}}, z2_rd} + {{3{ffwd_ff[W-1]}}, ffwd_ff}
            + {{3{appl_ff[W-1]}}, appl_ff} - {{3{gyro_ff[W-1]}}, gyro_ff};
   end

   // s = c0 - p, where p = 2 * (|e| * w0 >> 16) carries the sign of e
   always_comb begin
      p2    = {acc[63:16], 1'b0};
      if (e_neg_ff) begin
         s51 = {{16{c0_ff[34]}}, c0_ff} + {2'b00, p2};
      end else begin
         s51 = {{16{c0_ff[34]}}, c0_ff} - {2'b00, p2};
      end
      s_abs = s51[50] ? (51'd0 - s51) : s51;
   end

   // t = |s| * h >> 32, limited to 47 bits, then shifted up for the divide
   always_comb begin
      t47          = (|acc[81:79]) ? {47{1'b1}} : acc[78:32];
      div_dividend = {t47, 16'd0};
   end

   // z2 update: g = hb * |e| >> 16, opposite in sign to e
   always_comb begin
      g_big = |acc[79:49];
      g_lo  = acc[48:16];
      if (g_big) begin
         z2n_in = e_neg_ff ? SAT_MAX : SAT_MIN;
      end else if (e_neg_ff) begin
         z2n_in = sat35({{3{z2_ff[W-1]}}, z2_ff} + {2'b00, g_lo});
      end else begin
         z2n_in = sat35({{3{z2_ff[W-1]}}, z2_ff} - {2'b00, g_lo});
      end
   end

   // z1 update: d carries the sign of s
   always_comb begin
      d_big = |div_quo[62:33];
      d_lo  = div_quo[32:0];
      if (d_big) begin
         z1n = s_neg_ff ? SAT_MIN : SAT_MAX;
      end else if (s_neg_ff) begin
         z1n = sat35({{3{z1_ff[W-1]}}, z1_ff} - {2'b00, d_lo});
      end else begin
         z1n = sat35({{3{z1_ff[W-1]}}, z1_ff} + {2'b00, d_lo});
      end
   end

   // multiplier commands per step
   always_comb begin
      mul_cmd   = '0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_P_ISSUE: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b0, clear: 1'b1};
            mul_a   = me_ff;
            mul_b   = w0_ff;
         end
         ST_T_LO: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b0, clear: 1'b1};
            mul_a   = s_mag_ff[31:0];
            mul_b   = step_ff;
         end
         ST_T_HI: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b1, clear: 1'b0};
            mul_a   = {14'd0, s_mag_ff[49:32]};
            mul_b   = step_ff;
         end
         ST_DIV: begin
            // divider starts on t while the multiplier moves on to w0^2
            div_start = 1'b1;
            mul_cmd   = '{issue: 1'b1, upper: 1'b0, clear: 1'b1};
            mul_a     = w0_ff;
            mul_b     = w0_ff;
         end
         ST_HB_LO: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b0, clear: 1'b1};
            mul_a   = x_ff[31:0];
            mul_b   = step_ff;
         end
         ST_HB_HI: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b1, clear: 1'b0};
            mul_a   = {16'd0, x_ff[47:32]};
            mul_b   = step_ff;
         end
         ST_G_LO: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b0, clear: 1'b1};
            mul_a   = x_ff[31:0];
            mul_b   = me_ff;
         end
         ST_G_HI: begin
            mul_cmd = '{issue: 1'b1, upper: 1'b1, clear: 1'b0};
            mul_a   = {16'd0, x_ff[47:32]};
            mul_b   = me_ff;
         end
         default: begin
            mul_cmd = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_LOAD;
         ST_LOAD:    state_in = ax_ok ? ST_P_ISSUE : ST_FIN;
         ST_P_ISSUE: state_in = ST_P_WAIT;
         ST_P_WAIT:  state_in = ST_SUM;
         ST_SUM:     state_in = ST_T_LO;
         ST_T_LO:    state_in = ST_T_HI;
         ST_T_HI:    state_in = ST_T_WAIT;
         ST_T_WAIT:  state_in = ST_DIV;
         ST_DIV:     state_in = ST_B2_WAIT;
         ST_B2_WAIT: state_in = ST_B2;
         ST_B2:      state_in = ST_HB_LO;
         ST_HB_LO:   state_in = ST_HB_HI;
         ST_HB_HI:   state_in = ST_HB_WAIT;
         ST_HB_WAIT: state_in = ST_HB;
         ST_HB:      state_in = ST_G_LO;
         ST_G_LO:    state_in = ST_G_HI;
         ST_G_HI:    state_in = ST_G_WAIT;
         ST_G_WAIT:  state_in = ST_G;
         ST_G:       state_in = ST_FIN;
         ST_FIN:     if (finish) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         axis_ff    <= req_tuser;
         rate_ff    <= req_tdata[31:0];
         appl_ff    <= req_tdata[63:32];
         ffwd_ff    <= req_tdata[95:64];
         gyro_ff    <= req_tdata[127:96];
         // zero inertia counts as one lsb
         inertia_ff <= (req_tdata[158:128] == '0) ? JW'(1) : req_tdata[158:128];
      end
      unique case (state_ff)
         ST_LOAD: begin
            ax_ok_ff <= ax_ok;
            z1_ff    <= z1_rd;
            z2_ff    <= z2_rd;
            me_ff    <= e_abs[31:0];
            e_neg_ff <= e33[32];
            c0_ff    <= c0_in;
            w0_ff    <= w0_sel;
         end
         ST_SUM: begin
            s_mag_ff <= s_abs[49:0];
            s_neg_ff <= s51[50];
         end
         ST_B2: begin
            x_ff <= acc[63:16];
         end
         ST_HB: begin
            x_ff <= acc[79:32];
         end
         ST_G: begin
            z2n_ff <= z2n_in;
         end
         default: begin
            x_ff <= x_ff;
         end
      endcase
   end

   // estimate storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            obs_rate_ff[i] <= '0;
            obs_dist_ff[i] <= '0;
         end
      end else if (finish && ax_ok_ff) begin
         obs_rate_ff[idx] <= z1n;
         obs_dist_ff[idx] <= z2n_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_axis_ff <= axis_ff;
         rsp_rate_ff <= ax_ok_ff ? z1n : '0;
         rsp_dist_ff <= ax_ok_ff ? z2n_ff : '0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_axis_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_rate_ff};

endmodule
